### rtl/rfae_pkg.sv
// ----------------------------------------------------------------------------
// rfae_pkg
// Shared types and constants for the register file ALU executor.
// ----------------------------------------------------------------------------
package rfae_pkg;

  localparam int DEF_NUM_REGS   = 26;
  localparam int DEF_DATA_WIDTH = 32;

  localparam int OP_W  = 4;
  localparam int IDX_W = 5;
  localparam int IMM_W = 32;
  localparam int VAL_W = 32;

  localparam logic [OP_W-1:0] OP_IN   = 4'd0;
  localparam logic [OP_W-1:0] OP_MOV  = 4'd1;
  localparam logic [OP_W-1:0] OP_XCHG = 4'd2;
  localparam logic [OP_W-1:0] OP_ADD  = 4'd3;
  localparam logic [OP_W-1:0] OP_SUB  = 4'd4;
  localparam logic [OP_W-1:0] OP_MUL  = 4'd5;
  localparam logic [OP_W-1:0] OP_DIV  = 4'd6;
  localparam logic [OP_W-1:0] OP_MOD  = 4'd7;
  localparam logic [OP_W-1:0] OP_AND  = 4'd8;
  localparam logic [OP_W-1:0] OP_OR   = 4'd9;
  localparam logic [OP_W-1:0] OP_XOR  = 4'd10;
  localparam logic [OP_W-1:0] OP_OUT  = 4'd11;

  localparam logic STATUS_VALUE    = 1'b0;
  localparam logic STATUS_DIV_ZERO = 1'b1;

  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic [IDX_W-1:0]        dest;
    logic [IDX_W-1:0]        first_source;
    logic                    use_register;
    logic [IDX_W-1:0]        source_reg;
    logic signed [IMM_W-1:0] immediate;
  } instr_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    status;
  } result_t;

  typedef struct packed {
    logic            start;
    logic [OP_W-1:0] op;
  } alu_ctl_t;

endpackage

### rtl/rfae_regfile.sv
// ----------------------------------------------------------------------------
// rfae_regfile
// Register file memory, one write and two registered reads per cycle.
// Per-entry valid bits make unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module rfae_regfile #(
  parameter int NUM_REGS   = rfae_pkg::DEF_NUM_REGS,
  parameter int DATA_WIDTH = rfae_pkg::DEF_DATA_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [rfae_pkg::IDX_W-1:0] rd_idx_a,
  input  logic [rfae_pkg::IDX_W-1:0] rd_idx_b,
  output logic [DATA_WIDTH-1:0]      rd_data_a,
  output logic [DATA_WIDTH-1:0]      rd_data_b,
  input  logic                       wr_en,
  input  logic [rfae_pkg::IDX_W-1:0] wr_idx,
  input  logic [DATA_WIDTH-1:0]      wr_data
);
  import rfae_pkg::*;

  localparam int AW = $clog2(NUM_REGS);

  logic [DATA_WIDTH-1:0] mem [NUM_REGS];
  logic [NUM_REGS-1:0]   valid;

  logic [AW-1:0] addr_a;
  logic [AW-1:0] addr_b;
  logic [AW-1:0] addr_w;
  logic          hit_a;
  logic          hit_b;
  logic          wr_ok;

  assign addr_a = AW'(rd_idx_a);
  assign addr_b = AW'(rd_idx_b);
  assign addr_w = AW'(wr_idx);
  assign hit_a  = int'(rd_idx_a) < NUM_REGS;
  assign hit_b  = int'(rd_idx_b) < NUM_REGS;
  assign wr_ok  = wr_en && (int'(wr_idx) < NUM_REGS);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[addr_w] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_ok) begin
      valid[addr_w] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_a <= (hit_a && valid[addr_a]) ? mem[addr_a] : '0;
    rd_data_b <= (hit_b && valid[addr_b]) ? mem[addr_b] : '0;
  end

endmodule

### rtl/rfae_alu.sv
// ----------------------------------------------------------------------------
// rfae_alu
// Serial ALU: bit-serial add/sub/logic, shift-add multiply and restoring
// divide, one operand bit per cycle, then a finishing step that loads the result.
// ----------------------------------------------------------------------------
module rfae_alu #(
  parameter int DATA_WIDTH = rfae_pkg::DEF_DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rfae_pkg::alu_ctl_t    ctl,
  input  logic [DATA_WIDTH-1:0] a,
  input  logic [DATA_WIDTH-1:0] b,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] result
);
  import rfae_pkg::*;

  localparam int CW = $clog2(DATA_WIDTH + 1);
  localparam int DW = DATA_WIDTH;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIX} state_t;

  state_t          state;
  logic [OP_W-1:0] op;
  logic [CW-1:0]   cnt;
  logic [DW-1:0]   opa;
  logic [DW-1:0]   opb;
  logic [DW-1:0]   acc;
  logic            carry;
  logic            neg_q;
  logic            neg_r;

  logic          start_div;
  logic          run_div;
  logic          bb;
  logic          sum_bit;
  logic          cout;
  logic          ser_bit;
  logic [DW-1:0] mul_sum;
  logic [DW:0]   trial;
  logic [DW-1:0] mag_a;
  logic [DW-1:0] mag_b;
  logic [DW-1:0] quo_fix;
  logic [DW-1:0] rem_fix;

  assign start_div = (ctl.op == OP_DIV) || (ctl.op == OP_MOD);
  assign run_div   = (op == OP_DIV) || (op == OP_MOD);

  assign bb      = (op == OP_SUB) ? ~opb[0] : opb[0];
  assign sum_bit = opa[0] ^ bb ^ carry;
  assign cout    = (opa[0] & bb) | (opa[0] & carry) | (bb & carry);

  always_comb begin
    case (op)
      OP_AND:  ser_bit = opa[0] & opb[0];
      OP_OR:   ser_bit = opa[0] | opb[0];
      OP_XOR:  ser_bit = opa[0] ^ opb[0];
      default: ser_bit = sum_bit;
    endcase
  end

  assign mul_sum = acc + (opb[0] ? opa : '0);
  assign trial   = {acc, opa[DW-1]} - {1'b0, opb};
  assign mag_a   = a[DW-1] ? (DW'(0) - a) : a;
  assign mag_b   = b[DW-1] ? (DW'(0) - b) : b;
  assign quo_fix = neg_q ? (DW'(0) - opa) : opa;
  assign rem_fix = neg_r ? (DW'(0) - acc) : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (ctl.start) begin
            op    <= ctl.op;
            cnt   <= CW'(DW);
            acc   <= '0;
            carry <= (ctl.op == OP_SUB);
            neg_q <= a[DW-1] ^ b[DW-1];
            neg_r <= a[DW-1];
            opa   <= start_div ? mag_a : a;
            opb   <= start_div ? mag_b : b;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (op == OP_MUL) begin
            acc <= mul_sum;
            opa <= opa << 1;
            opb <= opb >> 1;
          end else if (run_div) begin
            acc <= trial[DW] ? {acc[DW-2:0], opa[DW-1]} : trial[DW-1:0];
            opa <= {opa[DW-2:0], ~trial[DW]};
          end else begin
            acc   <= {ser_bit, acc[DW-1:1]};
            opa   <= opa >> 1;
            opb   <= opb >> 1;
            carry <= cout;
          end
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            state <= S_FIX;
          end
        end
        S_FIX: begin
          if (op == OP_DIV) begin
            result <= quo_fix;
          end else if (op == OP_MOD) begin
            result <= rem_fix;
          end else begin
            result <= acc;
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.start |-> state == S_IDLE)
    else $error("alu started while busy");

  a_done_after_fix: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_FIX)
    else $error("alu done without finishing cycle");

  a_run_count: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> cnt != '0)
    else $error("alu bit counter underflow");

endmodule

### rtl/register_file_alu_executor.sv
// ----------------------------------------------------------------------------
// register_file_alu_executor
// Executes one decoded instruction per item on a zero-reset register file.
// ----------------------------------------------------------------------------
// An instruction is accepted only while the block is idle. IN, MOV, OUT,
// XCHG with an immediate operand and unused operation codes pass through
// the read and execute states and return to idle. XCHG with a register
// partner adds a second write-back state. ADD, SUB, MUL, DIV, MOD, AND, OR
// and XOR wait in a wait state: the serial ALU handles one operand bit per
// cycle and then a finishing step, around a registered register file read
// and write-back. A divide or modulo by zero starts no ALU run and returns
// from the execute state with status 1. A result waiting at the output does
// not hold off the next instruction unless that instruction itself has a
// result to give; then it waits in its execute state until the output
// register is free. Reset clears the register file at once through
// per-entry valid bits; there is no clearing sweep.
// ----------------------------------------------------------------------------
module register_file_alu_executor #(
  parameter int NUM_REGS   = rfae_pkg::DEF_NUM_REGS,
  parameter int DATA_WIDTH = rfae_pkg::DEF_DATA_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              instr_valid,
  output logic              instr_stall,
  input  rfae_pkg::instr_t  instr,
  output logic              result_valid,
  input  logic              result_stall,
  output rfae_pkg::result_t result
);
  import rfae_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_EXEC, S_XCHG2, S_WAIT} state_t;

  state_t  state;
  instr_t  ir;

  logic [IDX_W-1:0]      rd_idx_a;
  logic [DATA_WIDTH-1:0] rd_a;
  logic [DATA_WIDTH-1:0] rd_b;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_idx;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [DATA_WIDTH-1:0] imm_ext;
  logic [DATA_WIDTH-1:0] opnd_b;
  logic                  out_free;
  logic                  res_load;
  logic                  is_alu;
  logic                  is_div;
  logic                  b_zero;
  alu_ctl_t              alu_ctl;
  logic                  alu_done;
  logic [DATA_WIDTH-1:0] alu_result;

  assign instr_stall = (state != S_IDLE);

  assign rd_idx_a = ((ir.operation == OP_XCHG) || (ir.operation == OP_OUT)) ?
                    ir.dest : ir.first_source;
  assign imm_ext  = DATA_WIDTH'(ir.immediate);
  assign opnd_b   = ir.use_register ? rd_b : imm_ext;
  assign b_zero   = (opnd_b == '0);
  assign out_free = !result_valid || !result_stall;
  assign res_load = (state == S_EXEC) && out_free &&
                    ((ir.operation == OP_OUT) || (is_div && b_zero));

  assign is_div = (ir.operation == OP_DIV) || (ir.operation == OP_MOD);
  assign is_alu = (ir.operation == OP_ADD) || (ir.operation == OP_SUB) ||
                  (ir.operation == OP_MUL) || (ir.operation == OP_AND) ||
                  (ir.operation == OP_OR)  || (ir.operation == OP_XOR);

  assign alu_ctl.start = (state == S_EXEC) && (is_alu || (is_div && !b_zero));
  assign alu_ctl.op    = ir.operation;

  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = ir.dest;
    wr_data = opnd_b;
    case (state)
      S_EXEC: begin
        if ((ir.operation == OP_IN) || (ir.operation == OP_MOV)) begin
          wr_en = 1'b1;
        end else if ((ir.operation == OP_XCHG) && ir.use_register) begin
          wr_en   = 1'b1;
          wr_data = rd_b;
        end
      end
      S_XCHG2: begin
        wr_en   = 1'b1;
        wr_idx  = ir.source_reg;
        wr_data = rd_a;
      end
      S_WAIT: begin
        wr_en   = alu_done;
        wr_data = alu_result;
      end
      default: wr_en = 1'b0;
    endcase
  end

  rfae_regfile #(
    .NUM_REGS   (NUM_REGS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_regfile (
    .clk       (clk),
    .rst       (rst),
    .rd_idx_a  (rd_idx_a),
    .rd_idx_b  (ir.source_reg),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b),
    .wr_en     (wr_en),
    .wr_idx    (wr_idx),
    .wr_data   (wr_data)
  );

  rfae_alu #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_alu (
    .clk    (clk),
    .rst    (rst),
    .ctl    (alu_ctl),
    .a      (rd_a),
    .b      (opnd_b),
    .done   (alu_done),
    .result (alu_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && !res_load) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (instr_valid) begin
            ir    <= instr;
            state <= S_READ;
          end
        end
        S_READ: state <= S_EXEC;
        S_EXEC: begin
          if (ir.operation == OP_XCHG) begin
            state <= ir.use_register ? S_XCHG2 : S_IDLE;
          end else if (is_alu) begin
            state <= S_WAIT;
          end else if (is_div) begin
            if (!b_zero) begin
              state <= S_WAIT;
            end else if (out_free) begin
              result_valid  <= 1'b1;
              result.value  <= '0;
              result.status <= STATUS_DIV_ZERO;
              state         <= S_IDLE;
            end
          end else if (ir.operation == OP_OUT) begin
            if (out_free) begin
              result_valid  <= 1'b1;
              result.value  <= VAL_W'(signed'(rd_a));
              result.status <= STATUS_VALUE;
              state         <= S_IDLE;
            end
          end else begin
            state <= S_IDLE;
          end
        end
        S_XCHG2: state <= S_IDLE;
        S_WAIT: begin
          if (alu_done) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_write_on_accept: assert property (@(posedge clk) disable iff (rst)
    instr_valid && !instr_stall |-> !wr_en)
    else $error("register write while accepting an item");

  a_start_to_wait: assert property (@(posedge clk) disable iff (rst)
    alu_ctl.start |=> state == S_WAIT)
    else $error("alu started without waiting for it");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    alu_done |-> state == S_WAIT)
    else $error("alu result arrived outside wait state");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == S_EXEC)
    else $error("result loaded outside execute state");

endmodule

### bench/register_file_alu_executor_checker.sv
// ----------------------------------------------------------------------------
// register_file_alu_executor_checker
// Watches both channels of the executor and checks every result item.
// Every accepted instruction runs on a private copy of the register file.
// The results it should produce wait in order until the block delivers them,
// and each delivered result is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module register_file_alu_executor_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              instr_valid,
  input  logic              instr_stall,
  input  rfae_pkg::instr_t  instr,
  input  logic              result_valid,
  input  logic              result_stall,
  input  rfae_pkg::result_t result,
  output int                mismatches,
  output int                outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import rfae_pkg::*;

  localparam int NREGS = DEF_NUM_REGS;

  logic [VAL_W-1:0] shadow_regs [NREGS];
  result_t          awaited_results [$];

  function automatic logic [VAL_W-1:0] read_reg(logic [IDX_W-1:0] idx);
    return (idx < NREGS) ? shadow_regs[idx] : '0;
  endfunction

  function automatic void write_reg(logic [IDX_W-1:0] idx, logic [VAL_W-1:0] v);
    if (idx < NREGS) begin
      shadow_regs[idx] = v;
    end
  endfunction

  function automatic void execute_instr(instr_t ins);
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
    logic [VAL_W-1:0] t;
    longint           sa;
    longint           sb;
    longint           quot;
    result_t          r;
    b = ins.use_register ? read_reg(ins.source_reg) : ins.immediate;
    a = read_reg(ins.first_source);
    case (ins.operation)
      OP_IN, OP_MOV: write_reg(ins.dest, b);
      OP_XCHG: begin
        if (ins.use_register) begin
          t = read_reg(ins.dest);
          write_reg(ins.dest, read_reg(ins.source_reg));
          write_reg(ins.source_reg, t);
        end
      end
      OP_ADD: write_reg(ins.dest, a + b);
      OP_SUB: write_reg(ins.dest, a - b);
      OP_MUL: write_reg(ins.dest, a * b);
      OP_DIV, OP_MOD: begin
        if (b == '0) begin
          r.value  = '0;
          r.status = STATUS_DIV_ZERO;
          awaited_results.push_back(r);
        end else begin
          // 64-bit signed math: min / -1 fits, low bits give the wrapped quotient
          sa   = $signed(a);
          sb   = $signed(b);
          quot = (ins.operation == OP_DIV) ? sa / sb : sa % sb;
          write_reg(ins.dest, quot[VAL_W-1:0]);
        end
      end
      OP_AND: write_reg(ins.dest, a & b);
      OP_OR:  write_reg(ins.dest, a | b);
      OP_XOR: write_reg(ins.dest, a ^ b);
      OP_OUT: begin
        r.value  = read_reg(ins.dest);
        r.status = STATUS_VALUE;
        awaited_results.push_back(r);
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      foreach (shadow_regs[i]) shadow_regs[i] = '0;
      awaited_results.delete();
    end else begin
      if (instr_valid && !instr_stall) begin
        execute_instr(instr);
      end
      if (result_valid && !result_stall) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result with none expected: value %h status %b",
                   $time, result.value, result.status);
          mismatches = mismatches + 1;
        end else begin
          want = awaited_results.pop_front();
          if (result.value !== want.value || result.status !== want.status) begin
            $display("%0t: value expected %h got %h, status expected %b got %b",
                     $time, want.value, result.value, want.status, result.status);
            mismatches = mismatches + 1;
          end
        end
      end
    end
    outstanding = awaited_results.size();
  end

endmodule

### bench/tb_register_file_alu_executor.sv
// ----------------------------------------------------------------------------
// tb_register_file_alu_executor
// Stimulus and verdict for the register file ALU executor.
// A short directed run hits the overflow, divide and index corner cases, then
// random instructions with chained register use follow, with random idle
// bursts on both channels and a quiet stretch at the end. The checker beside
// the block predicts and compares; this module only drives and decides.
// ----------------------------------------------------------------------------
module tb_register_file_alu_executor;
  timeunit 1ns;
  timeprecision 1ps;
  import rfae_pkg::*;

  localparam int RANDOM_ITEMS = 1650;
  localparam int QUIET_FROM   = 1500;
  localparam int DRAIN_AT     = 700;

  logic    clk;
  logic    rst;
  logic    instr_valid;
  logic    instr_stall;
  instr_t  instr;
  logic    result_valid;
  logic    result_stall;
  result_t result;
  int      mismatches;
  int      outstanding;
  bit      quiet;

  register_file_alu_executor DUT (
    .clk          (clk),
    .rst          (rst),
    .instr_valid  (instr_valid),
    .instr_stall  (instr_stall),
    .instr        (instr),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  register_file_alu_executor_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .instr_valid  (instr_valid),
    .instr_stall  (instr_stall),
    .instr        (instr),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("register_file_alu_executor: mismatch");
    $finish;
  end

  initial begin
    bit hold;
    result_stall = 1'b0;
    forever begin
      hold = !quiet && ($urandom_range(0, 2) == 0);
      result_stall <= hold;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
  end

  function automatic instr_t mk(logic [OP_W-1:0] op, logic [IDX_W-1:0] d,
                                logic [IDX_W-1:0] s1, logic ur,
                                logic [IDX_W-1:0] s2, logic [IMM_W-1:0] imm);
    instr_t x;
    x.operation    = op;
    x.dest         = d;
    x.first_source = s1;
    x.use_register = ur;
    x.source_reg   = s2;
    x.immediate    = imm;
    return x;
  endfunction

  // mostly a few hot registers so values chain, sometimes out-of-range indexes
  function automatic logic [IDX_W-1:0] pick_reg();
    case ($urandom_range(0, 9))
      0:       return IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
      1, 2, 3: return IDX_W'($urandom_range(0, DEF_NUM_REGS - 1));
      default: return IDX_W'($urandom_range(0, 7));
    endcase
  endfunction

  function automatic logic [IMM_W-1:0] pick_imm();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 5))
          0:       return 32'h0000_0000;
          1:       return 32'h0000_0001;
          2:       return 32'hFFFF_FFFF;
          3:       return 32'h8000_0000;
          4:       return 32'h7FFF_FFFF;
          default: return 32'hFFFF_FFFE;
        endcase
      end
      1, 2:    return $urandom_range(0, 32) - 16;
      default: return $urandom;
    endcase
  endfunction

  function automatic instr_t random_instr();
    instr_t x;
    int     pick;
    pick = $urandom_range(0, 24);
    if (pick == 0) begin
      x.operation = OP_W'($urandom_range(OP_OUT + 1, {OP_W{1'b1}}));
    end else if (pick < 7) begin
      x.operation = OP_OUT;
    end else begin
      x.operation = OP_W'($urandom_range(OP_IN, OP_XOR));
    end
    x.dest         = pick_reg();
    x.first_source = ($urandom_range(0, 1) != 0) ? x.dest : pick_reg();
    x.use_register = 1'($urandom_range(0, 1));
    x.source_reg   = pick_reg();
    x.immediate    = pick_imm();
    return x;
  endfunction

  task automatic feed(input instr_t x);
    instr       <= x;
    instr_valid <= 1'b1;
    do @(posedge clk); while (instr_stall);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      instr_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
  endtask

  initial begin
    instr_t x;
    int     issued;
    rst         = 1'b1;
    instr_valid = 1'b0;
    instr       = '0;
    quiet       = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    feed(mk(OP_MOV,  0,  0, 1'b0,  0, 32'h8000_0000));
    feed(mk(OP_IN,   1,  0, 1'b0,  0, 32'h7FFF_FFFF));
    feed(mk(OP_MOV,  2,  0, 1'b0,  0, 32'hFFFF_FFFF));
    feed(mk(OP_ADD,  3,  1, 1'b0,  0, 32'h0000_0001));
    feed(mk(OP_SUB,  4,  0, 1'b1,  1, 32'h0000_0000));
    feed(mk(OP_MUL,  5,  1, 1'b1,  1, 32'h0000_0000));
    feed(mk(OP_DIV,  6,  0, 1'b1,  2, 32'h0000_0000));
    feed(mk(OP_MOD,  7,  0, 1'b1,  2, 32'h0000_0000));
    feed(mk(OP_OUT,  6,  0, 1'b0,  0, 32'h0000_0000));
    feed(mk(OP_DIV,  8,  1, 1'b0,  0, 32'h0000_0000));
    feed(mk(OP_MOD,  8,  1, 1'b1,  9, 32'h0000_0000));
    feed(mk(OP_DIV, 10,  0, 1'b0,  0, 32'h0000_0007));
    feed(mk(OP_MOD, 11,  0, 1'b0,  0, 32'hFFFF_FFF9));
    feed(mk(OP_AND, 12,  1, 1'b0,  0, 32'hF0F0_F0F0));
    feed(mk(OP_OR,  13,  0, 1'b1, 12, 32'h0000_0000));
    feed(mk(OP_XOR,  2,  2, 1'b1,  1, 32'h0000_0000));
    feed(mk(OP_XCHG, 0,  0, 1'b1,  1, 32'h0000_0000));
    feed(mk(OP_XCHG, 1,  0, 1'b0,  5, 32'h0000_0000));
    feed(mk(OP_MOV, 25,  0, 1'b1,  1, 32'h0000_0000));
    feed(mk(OP_XCHG, 25, 0, 1'b1, 30, 32'h0000_0000));
    feed(mk(OP_MOV, 31,  0, 1'b0,  0, 32'h0000_0005));
    feed(mk({OP_W{1'b1}}, 3, 3, 1'b0, 3, 32'h1234_5678));
    feed(mk(OP_OUT,  0,  0, 1'b0,  0, 32'h0000_0000));
    feed(mk(OP_OUT, 11,  0, 1'b0,  0, 32'h0000_0000));
    feed(mk(OP_OUT, 25,  0, 1'b0,  0, 32'h0000_0000));
    feed(mk(OP_OUT, 31,  0, 1'b0,  0, 32'h0000_0000));

    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      if (issued == DRAIN_AT) begin
        instr_valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
      end
      quiet = (issued >= QUIET_FROM);
      x = random_instr();
      feed(x);
      if (x.operation <= OP_OUT) issued++;
    end
    instr_valid <= 1'b0;

    do @(negedge clk); while (outstanding != 0);
    repeat (60) @(negedge clk);
    if (mismatches == 0) begin
      $display("register_file_alu_executor: match");
    end else begin
      $display("register_file_alu_executor: mismatch");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/rfae_pkg.sv
rtl/rfae_regfile.sv
rtl/rfae_alu.sv
rtl/register_file_alu_executor.sv
bench/register_file_alu_executor_checker.sv
bench/tb_register_file_alu_executor.sv
